@@ hdl/hmt_pkg.sv @@
// hmt_pkg: operation and status codes and the stored way format
// for the hash map table. No dependencies.
package hmt_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } way_t;

endpackage

@@ hdl/hash_map_table.sv @@
// hash_map_table: bucketed key-value table, one transaction at a time.
// The result is registered as S_LOOK ends. If NUM_BUCKETS is a power of two
// the row is read at accept, else after residue fold, reciprocal multiply and
// remainder fix (S_HASH1, S_HASH2). A new transaction is taken only after the
// bucket read / compare / write-back through the row memories is finished.
// Reset: a clearing pass writes every bucket of the valid memory,
// in_stall stays high meanwhile. Uses hmt_pkg.
module hash_map_table #(
  parameter int NUM_BUCKETS = 256,
  parameter int BUCKET_WAYS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] key,
  input  logic [31:0]        new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [31:0]        read_value
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int SW = 22;
  localparam int QW = SW + 1;
  localparam int PW = SW + QW;
  localparam int RW = BW + 1;
  localparam longint RECIP = (64'd1 << SW) / NUM_BUCKETS;
  localparam longint RES0 = 64'd1 % NUM_BUCKETS;
  localparam longint RES1 = (64'd1 << 8) % NUM_BUCKETS;
  localparam longint RES2 = (64'd1 << 16) % NUM_BUCKETS;
  localparam longint RES3 = (64'd1 << 24) % NUM_BUCKETS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH1 = 3'd2;
  localparam logic [2:0] S_HASH2 = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;

  logic [BUCKET_WAYS-1:0]              valid_mem [NUM_BUCKETS];
  logic [BUCKET_WAYS-1:0][63:0]        kv_mem    [NUM_BUCKETS];

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [BW-1:0]                       clr_idx;
  logic [1:0]                          cur_op;
  logic [31:0]                         cur_key;
  logic [31:0]                         cur_value;
  logic [BW-1:0]                       cur_bucket;
  logic [SW-1:0]                       fold_sum;
  logic [QW-1:0]                       quot;
  logic [BUCKET_WAYS-1:0]              valid_row;
  hmt_pkg::way_t [BUCKET_WAYS-1:0]     kv_row;

  logic                                accept;
  logic                                done;
  logic                                rd_en;
  logic [BW-1:0]                       rd_addr;
  logic [BW-1:0]                       bucket_pow2;
  logic [BW-1:0]                       bucket_mod;
  logic [SW-1:0]                       fold_next;
  logic [PW-1:0]                       recip_prod;
  logic [QW-1:0]                       qn_prod;
  logic [RW-1:0]                       rem_raw;
  logic [RW-1:0]                       rem_fix;
  logic                                vm_we;
  logic [BW-1:0]                       vm_waddr;
  logic [BUCKET_WAYS-1:0]              vm_wdata;
  logic                                kv_we;

  logic [BUCKET_WAYS-1:0]              hit_vec;
  logic                                hit_found;
  logic [WW-1:0]                       hit_way;
  logic                                free_found;
  logic [WW-1:0]                       free_way;
  logic [BUCKET_WAYS-1:0]              new_valid;
  hmt_pkg::way_t [BUCKET_WAYS-1:0]     new_kv;
  logic                                row_write;
  logic [1:0]                          res_status;
  logic [31:0]                         res_value;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state == S_LOOK) && (!out_valid || !out_stall);

  assign bucket_pow2 = (NUM_BUCKETS == 1) ? '0 : key[BW-1:0];

  assign fold_next = SW'(key[7:0])   * SW'(RES0) + SW'(key[15:8])  * SW'(RES1)
                   + SW'(key[23:16]) * SW'(RES2) + SW'(key[31:24]) * SW'(RES3);
  assign recip_prod = PW'(fold_sum) * PW'(RECIP);
  assign qn_prod    = quot * QW'(NUM_BUCKETS);
  assign rem_raw    = RW'(QW'(fold_sum) - qn_prod);
  assign rem_fix    = (rem_raw >= RW'(NUM_BUCKETS)) ? rem_raw - RW'(NUM_BUCKETS) : rem_raw;
  assign bucket_mod = (NUM_BUCKETS == 1) ? '0 : rem_fix[BW-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = bucket_mod;
    if (accept && IS_POW2) begin
      rd_en   = 1'b1;
      rd_addr = bucket_pow2;
    end else if (state == S_HASH2) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == BW'(NUM_BUCKETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = IS_POW2 ? S_LOOK : S_HASH1;
      end
      S_HASH1: state_next = S_HASH2;
      S_HASH2: state_next = S_LOOK;
      S_LOOK: begin
        if (done) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      hit_vec[w] = valid_row[w] && (kv_row[w].key == cur_key);
      if (!hit_found && hit_vec[w]) begin
        hit_found = 1'b1;
        hit_way   = WW'(w);
      end
      if (!free_found && !valid_row[w]) begin
        free_found = 1'b1;
        free_way   = WW'(w);
      end
    end
  end

  always_comb begin
    new_valid  = valid_row;
    new_kv     = kv_row;
    row_write  = 1'b0;
    res_status = hmt_pkg::ST_MISS;
    res_value  = '0;
    case (cur_op)
      hmt_pkg::OP_LOOKUP: begin
        if (hit_found) begin
          res_status = hmt_pkg::ST_OK;
          res_value  = kv_row[hit_way].value;
        end
      end
      hmt_pkg::OP_INSERT: begin
        if (hit_found) begin
          new_kv[hit_way].value = cur_value;
          row_write  = 1'b1;
          res_status = hmt_pkg::ST_OK;
        end else if (free_found) begin
          new_valid[free_way]    = 1'b1;
          new_kv[free_way].key   = cur_key;
          new_kv[free_way].value = cur_value;
          row_write  = 1'b1;
          res_status = hmt_pkg::ST_OK;
        end else begin
          res_status = hmt_pkg::ST_FULL;
        end
      end
      hmt_pkg::OP_REMOVE: begin
        if (hit_found) begin
          new_valid[hit_way] = 1'b0;
          row_write  = 1'b1;
          res_status = hmt_pkg::ST_OK;
        end
      end
      default: begin
        res_status = hmt_pkg::ST_MISS;
      end
    endcase
  end

  assign vm_we    = (state == S_CLEAR) || (done && row_write);
  assign vm_waddr = (state == S_CLEAR) ? clr_idx : cur_bucket;
  assign vm_wdata = (state == S_CLEAR) ? '0 : new_valid;
  assign kv_we    = done && row_write;

  always_ff @(posedge clk) begin
    if (vm_we) valid_mem[vm_waddr] <= vm_wdata;
    if (rd_en) valid_row <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (kv_we) kv_mem[cur_bucket] <= new_kv;
    if (rd_en) kv_row <= kv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + BW'(1);
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op    <= op;
      cur_key   <= key;
      cur_value <= new_value;
      fold_sum  <= fold_next;
    end
    if (state == S_HASH1) quot <= recip_prod[PW-1:SW];
    if (rd_en) cur_bucket <= rd_addr;
    if (done) begin
      status     <= res_status;
      read_value <= res_value;
    end
  end

  a_accept_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK || state == S_HASH1))
    else $error("accepted transaction did not advance");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH2) |-> (rem_fix < RW'(NUM_BUCKETS)))
    else $error("bucket remainder out of range");

  a_no_duplicate_key: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $onehot0(hit_vec))
    else $error("key present in more than one way");

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (done && res_status == hmt_pkg::ST_FULL) |->
      (cur_op == hmt_pkg::OP_INSERT && (&valid_row)))
    else $error("full status without a full bucket on insert");

  a_no_write_while_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && !done) |-> !vm_we && !kv_we)
    else $error("row written before the result could be taken");

endmodule
